@@ design/bhpq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bhpq_pkg: shared types and codes
// Payload structs and action and status codes of the heap priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

	localparam logic [1:0] ACT_ENQ   = 2'd0;
	localparam logic [1:0] ACT_DEQ   = 2'd1;
	localparam logic [1:0] ACT_CHG   = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_NOT_LESS  = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	typedef struct packed {
		logic [1:0]         action;
		logic [15:0]        value_id;
		logic signed [31:0] priority_req;
	} bhpq_req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [15:0]        removed_value;
		logic [15:0]        top_value;
		logic signed [31:0] top_priority;
		logic [10:0]        entry_count;
		logic               is_empty;
	} bhpq_rsp_t;

	typedef struct packed {
		logic [15:0]        vid;
		logic signed [31:0] pri;
	} bhpq_entry_t;

	// True when entry a must come before entry b.
	function automatic logic entry_less(input bhpq_entry_t a, input bhpq_entry_t b);
		if (a.pri != b.pri) begin
			return a.pri < b.pri;
		end
		return a.vid < b.vid;
	endfunction

endpackage
`default_nettype wire

@@ design/bhpq_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bhpq_mem: heap slot storage
// Synchronous memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bhpq_mem import bhpq_pkg::*; #(
	parameter int Depth = 1024,
	parameter int AddrW = 10
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AddrW-1:0] waddr,
	input  wire bhpq_entry_t      wdata,
	input  wire logic [AddrW-1:0] raddr,
	output bhpq_entry_t           rdata
);

	bhpq_entry_t mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ design/binary_heap_priority_queue_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_top: binary min-heap priority queue
// Keeps (value id, priority) entries in one slot memory and performs
// enqueue, dequeue, change-priority and clear as read-modify-write sequences.
// ----------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------
//  request   | start && !busy         | req  (action, value_id, priority_req)
//  result    | done, one cycle        | rsp  (status, removed, top, count)
//
// Clear, enqueue when full and dequeue when empty go straight to the final
// root read. Enqueue reads and compares the parent at each level climbed.
// Dequeue reads the left child, then the right child, then compares, at each
// level descended. Change-priority scans the slots in order, then sifts up
// the entry when it is found and the new priority is lower.
// Reset clears the fill count, status and removed value; slot contents stay
// undefined because slots at or above the count are never used. The receiver cannot stall.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_top import bhpq_pkg::*; #(
	parameter int CAPACITY = 1024
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire bhpq_req_t req,
	output logic           busy,
	output logic           done,
	output bhpq_rsp_t      rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = CW + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_CHK,
		S_UP_RD, S_UP_CMP,
		S_DN_LOAD, S_DN_RDL, S_DN_RDR, S_DN_CMP,
		S_FIN, S_ROOT
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      pos_q;      // 1-based position of the moving entry
	bhpq_req_t          req_q;
	bhpq_entry_t        cur_q, lch_q, top_q;
	logic [2:0]         status_q;
	logic [15:0]        removed_q;

	logic               we;
	logic [AW-1:0]      waddr, raddr;
	bhpq_entry_t        wdata, rdata;

	bhpq_mem #(.Depth(CAPACITY), .AddrW(AW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// Child positions can exceed the count width, so they carry one more bit.
	logic [PW-1:0] lpos, rpos, count_ext;
	logic [CW-1:0] ppos;
	assign lpos      = {pos_q, 1'b0};
	assign rpos      = {pos_q, 1'b1};
	assign count_ext = {1'b0, count_q};
	assign ppos      = pos_q >> 1;

	// Sift-down choice: the smaller of the moving entry and its children.
	// The right child is in rdata during S_DN_CMP and only counts when it exists.
	logic        take_l, take_r, up_swap;
	bhpq_entry_t dn_best;
	always_comb begin
		take_l  = entry_less(lch_q, cur_q);
		dn_best = take_l ? lch_q : cur_q;
		take_r  = (rpos <= count_ext) && entry_less(rdata, dn_best);
		if (take_r) begin
			dn_best = rdata;
		end
		up_swap = entry_less(cur_q, rdata);
	end

	// Memory address and write selection per state.
	always_comb begin
		we    = 1'b0;
		waddr = AW'(pos_q - 1'b1);
		wdata = cur_q;
		raddr = AW'(pos_q - 1'b1);
		case (state_q)
			S_IDLE: raddr = AW'(count_q - 1'b1);
			S_UP_RD: begin
				if (pos_q == CW'(1)) begin
					we = 1'b1;
				end else begin
					raddr = AW'(ppos - 1'b1);
				end
			end
			S_UP_CMP: begin
				// The parent moves down, or the moving entry settles here.
				we    = 1'b1;
				wdata = up_swap ? rdata : cur_q;
			end
			S_DN_RDL: begin
				if (lpos > count_ext) begin
					we = 1'b1;
				end else begin
					raddr = AW'(lpos - 1'b1);
				end
			end
			S_DN_RDR: raddr = AW'(rpos - 1'b1);
			S_DN_CMP: begin
				we    = 1'b1;
				wdata = dn_best;
			end
			S_FIN:    raddr = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			busy      <= 1'b0;
			done      <= 1'b0;
			status_q  <= ST_OK;
			removed_q <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q     <= req;
						busy      <= 1'b1;
						status_q  <= ST_OK;
						removed_q <= '0;
						case (req.action)
							ACT_ENQ: begin
								if (count_q >= CW'(CAPACITY)) begin
									status_q <= ST_FULL;
									state_q  <= S_FIN;
								end else begin
									cur_q   <= '{vid: req.value_id, pri: req.priority_req};
									count_q <= count_q + 1'b1;
									pos_q   <= count_q + 1'b1;
									state_q <= S_UP_RD;
								end
							end
							ACT_DEQ: begin
								if (count_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_FIN;
								end else begin
									// The last slot is being read at this edge.
									removed_q <= top_q.vid;
									count_q   <= count_q - 1'b1;
									state_q   <= S_DN_LOAD;
								end
							end
							ACT_CHG: begin
								status_q <= ST_NOT_FOUND;
								pos_q    <= CW'(1);
								state_q  <= (count_q == '0) ? S_FIN : S_SCAN_RD;
							end
							default: begin
								count_q <= '0;
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_CHK;
				S_SCAN_CHK: begin
					if (rdata.vid == req_q.value_id) begin
						if (req_q.priority_req < rdata.pri) begin
							status_q <= ST_OK;
							cur_q    <= '{vid: rdata.vid, pri: req_q.priority_req};
							state_q  <= S_UP_RD;
						end else begin
							status_q <= ST_NOT_LESS;
							state_q  <= S_FIN;
						end
					end else if (pos_q == count_q) begin
						state_q <= S_FIN;
					end else begin
						pos_q   <= pos_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				// Sift up: cur_q is the moving entry, written only once it settles.
				S_UP_RD: begin
					state_q <= (pos_q == CW'(1)) ? S_FIN : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (up_swap) begin
						pos_q   <= ppos;
						state_q <= S_UP_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				// Sift down: the former last entry starts at the root.
				S_DN_LOAD: begin
					cur_q   <= rdata;
					pos_q   <= CW'(1);
					state_q <= S_DN_RDL;
				end
				S_DN_RDL: begin
					state_q <= (lpos > count_ext) ? S_FIN : S_DN_RDR;
				end
				S_DN_RDR: begin
					lch_q   <= rdata;
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (take_r) begin
						pos_q   <= CW'(rpos);
						state_q <= S_DN_RDL;
					end else if (take_l) begin
						pos_q   <= CW'(lpos);
						state_q <= S_DN_RDL;
					end else begin
						state_q <= S_FIN;
					end
				end
				// The root is read after the last write so the result shows it.
				S_FIN: state_q <= S_ROOT;
				S_ROOT: begin
					top_q   <= rdata;
					busy    <= 1'b0;
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		rsp.status        = status_q;
		rsp.removed_value = removed_q;
		rsp.entry_count   = 11'(count_q);
		rsp.is_empty      = (count_q == '0);
		rsp.top_value     = (count_q == '0) ? 16'd0 : top_q.vid;
		rsp.top_priority  = (count_q == '0) ? 32'sd0 : top_q.pri;
	end

endmodule
`default_nettype wire
